// ===== src/tsl_pkg.sv =====
// Shared types, constants and lookup for the tempo-synced LFO.
// No dependencies; used by every other file in src.
package tsl_pkg;

	// Fixed field widths
	localparam int BPM_W   = 10;
	localparam int SR_W    = 18;
	localparam int DIV_W   = 4;
	localparam int SHAPE_W = 2;
	localparam int SEED_W  = 16;
	localparam int CFG_W   = 18;
	localparam int CIDX_W  = 3;
	localparam int BLK_W   = 13;
	localparam int LUT_W   = 16;   // 60 * beats48 fits in 16 bits
	localparam int DEN_W   = LUT_W + SR_W;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_RATE_DIVISION  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_WAVE_SHAPE     = 3'd1;
	localparam logic [CIDX_W-1:0] REG_TEMPO_BPM      = 3'd2;
	localparam logic [CIDX_W-1:0] REG_SAMPLE_RATE_HZ = 3'd3;
	localparam logic [CIDX_W-1:0] REG_RANDOM_SEED    = 3'd4;

	// Item kinds
	localparam logic KIND_ADVANCE = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// Wave shapes
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SAW_DOWN = 2'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_SAMPLE_HOLD = 2'd3;

	// Reset values
	localparam logic [DIV_W-1:0]   RST_RATE_DIVISION  = 4'd4;
	localparam logic [SHAPE_W-1:0] RST_WAVE_SHAPE     = 2'd0;
	localparam logic [BPM_W-1:0]   RST_TEMPO_BPM      = 10'd120;
	localparam logic [SR_W-1:0]    RST_SAMPLE_RATE_HZ = 18'd48000;
	localparam logic [SEED_W-1:0]  RST_RANDOM_SEED    = 16'd1;

	localparam logic [SEED_W-1:0]  LFSR_MASK = 16'hB400;

	typedef struct packed {
		logic             kind;
		logic [BLK_W-1:0] block_samples;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] lfo_value;
		logic [31:0]        phase_now;
		logic               cycle_wrapped;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic whole_nz;   // integer part of the quotient is non-zero
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_NUM,
		ST_MUL_DEN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ADD,
		ST_WAVE
	} state_t;

	// 60 * note length in 1/48 beat; out-of-range divisions read as 4 bars
	function automatic logic [LUT_W-1:0] div_len60(input logic [DIV_W-1:0] div);
		logic [LUT_W-1:0] r;
		case (div)
			4'd0: r = 16'd720;
			4'd1: r = 16'd480;
			4'd2: r = 16'd1440;
			4'd3: r = 16'd960;
			4'd4: r = 16'd2880;
			4'd5: r = 16'd1920;
			4'd6: r = 16'd5760;
			4'd7: r = 16'd11520;
			4'd8: r = 16'd23040;
			default: r = 16'd46080;
		endcase
		return r;
	endfunction

endpackage

// ===== src/tsl_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the phase increment.
// Depends on tsl_pkg. Gives the fractional quotient and a non-zero flag for the integer part.
module tsl_divider #(
	parameter int NUM_W      = 29,
	parameter int PHASE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NUM_W-1:0]            num,
	input  logic [tsl_pkg::DEN_W-1:0]   den,
	output tsl_pkg::div_stat_t          stat,
	output logic [PHASE_BITS-1:0]       frac
);

	localparam int STEPS  = NUM_W + PHASE_BITS;
	localparam int STEP_W = $clog2(STEPS);

	logic                        busy_q;
	logic                        done_q;
	logic                        whole_q;
	logic [STEP_W-1:0]           step_q;
	logic [NUM_W-1:0]            num_q;
	logic [tsl_pkg::DEN_W-1:0]   den_q;
	logic [tsl_pkg::DEN_W-1:0]   rem_q;
	logic [PHASE_BITS-1:0]       frac_q;

	logic [tsl_pkg::DEN_W:0]     trial;
	logic [tsl_pkg::DEN_W:0]     den_ext;
	logic [tsl_pkg::DEN_W:0]     diff;
	logic                        ge;
	logic                        last_step;
	logic                        int_phase;

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign den_ext   = {1'b0, den_q};
	assign diff      = trial - den_ext;
	assign ge        = (trial >= den_ext);
	assign last_step = (step_q == STEP_W'(STEPS - 1));
	assign int_phase = (step_q < STEP_W'(NUM_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			whole_q <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= busy_q & last_step;
			if (start) begin
				busy_q  <= 1'b1;
				whole_q <= 1'b0;
				step_q  <= '0;
			end else if (busy_q) begin
				if (int_phase && ge)
					whole_q <= 1'b1;
				if (last_step)
					busy_q <= 1'b0;
				else
					step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			frac_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[tsl_pkg::DEN_W-1:0] : trial[tsl_pkg::DEN_W-1:0];
			if (!int_phase)
				frac_q <= {frac_q[PHASE_BITS-2:0], ge};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.whole_nz = whole_q;
	assign frac          = frac_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held over two cycles");

endmodule

// ===== src/tsl_wave.sv =====
// Waveform shaper: maps a 32-bit phase to a Q1.15 triangle, saw, square or held value.
// Depends on tsl_pkg.
module tsl_wave (
	input  logic [31:0]                    phase,
	input  logic [tsl_pkg::SHAPE_W-1:0]    shape,
	input  logic [15:0]                    held,
	output logic signed [15:0]             value
);

	logic [31:0]        d_mid;
	logic [31:0]        d_top;
	logic signed [17:0] v;

	assign d_mid = phase - 32'h4000_0000;
	assign d_top = phase - 32'hC000_0000;

	always_comb begin
		case (shape)
			tsl_pkg::SHAPE_TRIANGLE: begin
				if (phase < 32'h4000_0000)
					v = $signed({3'b000, phase[29:15]});
				else if (phase < 32'hC000_0000)
					v = 18'sd32768 - $signed({1'b0, d_mid[31:15]});
				else
					v = -18'sd32768 + $signed({1'b0, d_top[31:15]});
			end
			tsl_pkg::SHAPE_SAW_DOWN:
				v = 18'sd32768 - $signed({2'b00, phase[31:16]});
			tsl_pkg::SHAPE_SQUARE:
				v = phase[31] ? -18'sd32768 : 18'sd32767;
			default:
				v = 18'(signed'(held));
		endcase
	end

	// only +1 can overflow
	assign value = (v > 18'sd32767) ? 16'sh7FFF : v[15:0];

endmodule

// ===== src/tempo_synced_lfo.sv =====
// Tempo-synced LFO: PHASE_BITS-bit phase accumulator with tempo-derived increment.
// Depends on tsl_pkg, tsl_divider and tsl_wave.
//
// An advance item is turned into a phase increment of
// floor(2^PHASE_BITS * bpm * 48 * count / (60 * beats48 * fs)): two products through
// one shared 16 x 18 multiplier, then a restoring divider that yields one quotient bit per cycle
// over 16 + clog2(MAX_BLOCK+1) integer bits and PHASE_BITS fraction bits. An advance passes through
// the states MUL_NUM, MUL_DEN, DIV_GO, DIV_WAIT, ADD and WAVE; a restart goes straight to WAVE.
// in_stall stays high until the result is loaded, and a finished result waits in the output register
// while the next item is taken. The integer part of the quotient only sets cycle_wrapped; in
// sample-and-hold shape a wrap steps the LFSR once. Configuration is to be written only while
// idle, which the block itself does not enforce; writing random_seed loads the LFSR.
module tempo_synced_lfo #(
	parameter int PHASE_BITS = 32,
	parameter int MAX_BLOCK  = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [tsl_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [tsl_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tsl_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tsl_pkg::out_item_t            out_item
);

	localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
	localparam int MB_W   = (CNT_W > tsl_pkg::SR_W) ? CNT_W : tsl_pkg::SR_W;
	localparam int PROD_W = tsl_pkg::LUT_W + MB_W;
	localparam int NUM_W  = tsl_pkg::LUT_W + CNT_W;

	tsl_pkg::state_t state_q, state_d;

	logic [tsl_pkg::DIV_W-1:0]   rate_division_q;
	logic [tsl_pkg::SHAPE_W-1:0] wave_shape_q;
	logic [tsl_pkg::BPM_W-1:0]   tempo_bpm_q;
	logic [tsl_pkg::SR_W-1:0]    srate_hz_q;

	logic [PHASE_BITS-1:0]       phase_q;
	logic [15:0]                 held_q;
	logic [15:0]                 lfsr_q;
	logic                        wrapped_q;

	logic [CNT_W-1:0]            cnt_q;
	logic [NUM_W-1:0]            num_q;
	logic [tsl_pkg::DEN_W-1:0]   den_q;

	logic                        out_valid_q;
	tsl_pkg::out_item_t          out_q;

	logic                        accept;
	logic                        div_start;
	logic                        out_load;
	tsl_pkg::div_stat_t          div_stat;
	logic [PHASE_BITS-1:0]       div_frac;

	logic [tsl_pkg::LUT_W-1:0]   bpm48;
	logic [tsl_pkg::SR_W-1:0]    sr_eff;
	logic [tsl_pkg::LUT_W-1:0]   mul_a;
	logic [MB_W-1:0]             mul_b;
	logic [PROD_W-1:0]           mul_p;

	logic [PHASE_BITS:0]         add_sum;
	logic                        add_wrap;
	logic [15:0]                 lfsr_src;
	logic [15:0]                 lfsr_next;

	logic [PHASE_BITS+31:0]      phase_ext;
	logic [31:0]                 phase_u;
	logic signed [15:0]          wave_v;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (state_q != tsl_pkg::ST_IDLE);

	// Shared multiplier: count term first, then the note-length term
	assign bpm48  = tsl_pkg::LUT_W'({tempo_bpm_q, 5'b0}) + tsl_pkg::LUT_W'({tempo_bpm_q, 4'b0});
	assign sr_eff = (srate_hz_q == '0) ? tsl_pkg::SR_W'(1) : srate_hz_q;
	assign mul_a  = (state_q == tsl_pkg::ST_MUL_NUM) ? bpm48 :
	                tsl_pkg::div_len60(rate_division_q);
	assign mul_b  = (state_q == tsl_pkg::ST_MUL_NUM) ? MB_W'(cnt_q) : MB_W'(sr_eff);
	assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign add_sum  = {1'b0, phase_q} + {1'b0, div_frac};
	assign add_wrap = div_stat.whole_nz | add_sum[PHASE_BITS];

	assign lfsr_src  = (lfsr_q == 16'd0) ? 16'd1 : lfsr_q;
	assign lfsr_next = {1'b0, lfsr_src[15:1]} ^ (lfsr_src[0] ? tsl_pkg::LFSR_MASK : 16'd0);

	// Top 32 bits of the phase, zero-filled below when the phase is narrower
	assign phase_ext = {phase_q, 32'd0};
	assign phase_u   = phase_ext[PHASE_BITS+31 -: 32];

	tsl_divider #(
		.NUM_W      (NUM_W),
		.PHASE_BITS (PHASE_BITS)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.stat   (div_stat),
		.frac   (div_frac)
	);

	tsl_wave u_wave (
		.phase (phase_u),
		.shape (wave_shape_q),
		.held  (held_q),
		.value (wave_v)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			tsl_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = (in_item.kind == tsl_pkg::KIND_RESTART) ?
					          tsl_pkg::ST_WAVE : tsl_pkg::ST_MUL_NUM;
			end
			tsl_pkg::ST_MUL_NUM: state_d = tsl_pkg::ST_MUL_DEN;
			tsl_pkg::ST_MUL_DEN: state_d = tsl_pkg::ST_DIV_GO;
			tsl_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = tsl_pkg::ST_DIV_WAIT;
			end
			tsl_pkg::ST_DIV_WAIT: begin
				if (div_stat.done)
					state_d = tsl_pkg::ST_ADD;
			end
			tsl_pkg::ST_ADD: state_d = tsl_pkg::ST_WAVE;
			tsl_pkg::ST_WAVE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = tsl_pkg::ST_IDLE;
				end
			end
			default: state_d = tsl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tsl_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_division_q <= tsl_pkg::RST_RATE_DIVISION;
			wave_shape_q    <= tsl_pkg::RST_WAVE_SHAPE;
			tempo_bpm_q     <= tsl_pkg::RST_TEMPO_BPM;
			srate_hz_q      <= tsl_pkg::RST_SAMPLE_RATE_HZ;
			phase_q         <= '0;
			held_q          <= '0;
			lfsr_q          <= tsl_pkg::RST_RANDOM_SEED;
			wrapped_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					tsl_pkg::REG_RATE_DIVISION:
						rate_division_q <= cfg_data[tsl_pkg::DIV_W-1:0];
					tsl_pkg::REG_WAVE_SHAPE:
						wave_shape_q <= cfg_data[tsl_pkg::SHAPE_W-1:0];
					tsl_pkg::REG_TEMPO_BPM:
						tempo_bpm_q <= cfg_data[tsl_pkg::BPM_W-1:0];
					tsl_pkg::REG_SAMPLE_RATE_HZ:
						srate_hz_q <= cfg_data[tsl_pkg::SR_W-1:0];
					tsl_pkg::REG_RANDOM_SEED: begin
						lfsr_q <= cfg_data[tsl_pkg::SEED_W-1:0];
					end
					default: ;
				endcase
			end
			if (accept && in_item.kind == tsl_pkg::KIND_RESTART) begin
				phase_q   <= '0;
				wrapped_q <= 1'b0;
			end
			if (state_q == tsl_pkg::ST_ADD) begin
				phase_q   <= add_sum[PHASE_BITS-1:0];
				wrapped_q <= add_wrap;
				if (add_wrap && wave_shape_q == tsl_pkg::SHAPE_SAMPLE_HOLD) begin
					lfsr_q <= lfsr_next;
					held_q <= lfsr_next;
				end
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (32'(in_item.block_samples) > 32'(MAX_BLOCK))
				cnt_q <= CNT_W'(MAX_BLOCK);
			else
				cnt_q <= CNT_W'(in_item.block_samples);
		end
		if (state_q == tsl_pkg::ST_MUL_NUM)
			num_q <= NUM_W'(mul_p);
		if (state_q == tsl_pkg::ST_MUL_DEN)
			den_q <= tsl_pkg::DEN_W'(mul_p);
		if (out_load) begin
			out_q.lfo_value     <= wave_v;
			out_q.phase_now     <= phase_u;
			out_q.cycle_wrapped <= wrapped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_result_from_wave: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tsl_pkg::ST_WAVE))
		else $error("result appeared outside the wave state");

	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tsl_pkg::ST_ADD &&
		 !(accept && in_item.kind == tsl_pkg::KIND_RESTART)) |=> $stable(phase_q))
		else $error("phase moved outside an update");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsl_pkg::ST_DIV_WAIT) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");

endmodule

// ===== verif/tb_tempo_synced_lfo.sv =====
// Self-checking testbench for tempo_synced_lfo: directed defaults, landmarks, range limits and
// sample-and-hold, then randomised blocks and settings around a long output back-pressure run.
// Depends on tsl_pkg and the RTL in src; needs no other files.
module tb_tempo_synced_lfo;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BLOCK       = 4096;
	localparam int ADVANCE_LATENCY = 67;
	localparam int HOLD_CYCLES     = 300;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int BEATS48 [10]    = '{12, 8, 24, 16, 48, 32, 96, 192, 384, 768};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic [tsl_pkg::CIDX_W-1:0]  cfg_index;
	logic [tsl_pkg::CFG_W-1:0]   cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	tsl_pkg::in_item_t           in_item;
	logic                        out_valid;
	logic                        out_stall;
	tsl_pkg::out_item_t          out_item;

	// Predictor copy of the registers and state
	logic [tsl_pkg::DIV_W-1:0]   r_div;
	logic [tsl_pkg::SHAPE_W-1:0] r_shape;
	logic [tsl_pkg::BPM_W-1:0]   r_bpm;
	logic [tsl_pkg::SR_W-1:0]    r_sr;
	logic [31:0]                 lfo_phase;
	logic [15:0]                 sh_value;
	logic [15:0]                 lfsr;

	tsl_pkg::out_item_t expected_lfo[$];
	int        errors = 0;
	int        cycle_count = 0;
	int        tx_idle_pct;
	int        rx_idle_pct;
	logic      long_hold;
	int        held_cycles = 0;

	tempo_synced_lfo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_tempo_synced_lfo: errors");
		$finish;
	end

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endfunction

	function automatic tsl_pkg::in_item_t mk_item(logic kind, int blk);
		tsl_pkg::in_item_t it;
		it.kind = kind;
		it.block_samples = tsl_pkg::BLK_W'(blk);
		return it;
	endfunction

	function automatic logic signed [15:0] shape_value(logic [31:0] u);
		int v;
		case (r_shape)
			tsl_pkg::SHAPE_TRIANGLE: begin
				if (u < 32'h4000_0000)
					v = int'(u >> 15);
				else if (u < 32'hC000_0000)
					v = 32768 - int'((u - 32'h4000_0000) >> 15);
				else
					v = -32768 + int'((u - 32'hC000_0000) >> 15);
			end
			tsl_pkg::SHAPE_SAW_DOWN: v = 32768 - int'(u >> 16);
			tsl_pkg::SHAPE_SQUARE:   v = (u < 32'h8000_0000) ? 32767 : -32768;
			default:                 v = int'($signed(sh_value));
		endcase
		if (v > 32767)
			v = 32767;
		return 16'(v);
	endfunction

	// Works out the result of one accepted item and queues it
	function automatic void advance_lfo(tsl_pkg::in_item_t it);
		tsl_pkg::out_item_t res;
		logic [12:0] cnt;
		logic [17:0] sr;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] whole;
		logic [63:0] rem;
		logic [95:0] frac;
		logic [32:0] sum;
		logic [15:0] r;
		logic        wrapped;
		int          div_i;
		wrapped = 1'b0;
		if (it.kind == tsl_pkg::KIND_RESTART) begin
			lfo_phase = '0;
		end else begin
			cnt = (it.block_samples > MAX_BLOCK) ? 13'(MAX_BLOCK) : it.block_samples;
			div_i = (r_div > 9) ? 9 : int'(r_div);
			sr = (r_sr == 0) ? 18'd1 : r_sr;
			num = 64'(r_bpm) * 64'd48 * 64'(cnt);
			den = 64'd60 * 64'(BEATS48[div_i]) * 64'(sr);
			whole = num / den;
			rem = num % den;
			frac = {rem, 32'd0} / {32'd0, den};
			sum = {1'b0, lfo_phase} + {1'b0, frac[31:0]};
			wrapped = (whole != 0) || sum[32];
			lfo_phase = sum[31:0];
			// Galois LFSR, one step per wrap however many cycles were crossed
			if (wrapped && r_shape == tsl_pkg::SHAPE_SAMPLE_HOLD) begin
				r = (lfsr == 0) ? 16'd1 : lfsr;
				r = r[0] ? ((r >> 1) ^ tsl_pkg::LFSR_MASK) : (r >> 1);
				lfsr = r;
				sh_value = r;
			end
		end
		res.lfo_value = shape_value(lfo_phase);
		res.phase_now = lfo_phase;
		res.cycle_wrapped = wrapped;
		expected_lfo.push_back(res);
	endfunction

	function automatic tsl_pkg::in_item_t random_item();
		int pick;
		int blk;
		pick = $urandom_range(99);
		if (pick < 6)
			return mk_item(tsl_pkg::KIND_RESTART, $urandom_range(8191));
		if (pick < 16)
			blk = $urandom_range(63);
		else if (pick < 80)
			blk = $urandom_range(MAX_BLOCK, 64);
		else if (pick < 88)
			blk = MAX_BLOCK;
		else
			blk = $urandom_range(8191, MAX_BLOCK + 1);
		return mk_item(tsl_pkg::KIND_ADVANCE, blk);
	endfunction

	task automatic send_item(tsl_pkg::in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item = it;
		do
			@(posedge clk);
		while (in_stall);
		advance_lfo(it);
	endtask

	// Every item yields a result, so an empty queue means the block is idle
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_lfo.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [tsl_pkg::CIDX_W-1:0] idx, int unsigned value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = tsl_pkg::CFG_W'(value);
		case (idx)
			tsl_pkg::REG_RATE_DIVISION:  r_div = tsl_pkg::DIV_W'(value);
			tsl_pkg::REG_WAVE_SHAPE:     r_shape = tsl_pkg::SHAPE_W'(value);
			tsl_pkg::REG_TEMPO_BPM:      r_bpm = tsl_pkg::BPM_W'(value);
			tsl_pkg::REG_SAMPLE_RATE_HZ: r_sr = tsl_pkg::SR_W'(value);
			tsl_pkg::REG_RANDOM_SEED: begin
				lfsr = tsl_pkg::SEED_W'(value);
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic pick_setting();
		int p;
		if ($urandom_range(99) < 70)
			write_reg(tsl_pkg::REG_RATE_DIVISION,
				($urandom_range(99) < 10) ? $urandom_range(15, 10) : $urandom_range(9));
		if ($urandom_range(99) < 70)
			write_reg(tsl_pkg::REG_WAVE_SHAPE, $urandom_range(3));
		if ($urandom_range(99) < 60) begin
			p = $urandom_range(99);
			if (p < 5)
				write_reg(tsl_pkg::REG_TEMPO_BPM, 0);
			else if (p < 10)
				write_reg(tsl_pkg::REG_TEMPO_BPM, $urandom_range(1023, 1000));
			else if (p < 15)
				write_reg(tsl_pkg::REG_TEMPO_BPM, $urandom_range(1) ? 999 : 20);
			else
				write_reg(tsl_pkg::REG_TEMPO_BPM, $urandom_range(999, 20));
		end
		if ($urandom_range(99) < 50) begin
			case ($urandom_range(9))
				0: write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 0);
				1: write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, $urandom_range(262143));
				2: write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 8000);
				3: write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 44100);
				4: write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 96000);
				5: write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 192000);
				default: write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, $urandom_range(192000, 8000));
			endcase
		end
		if ($urandom_range(99) < 25)
			write_reg(tsl_pkg::REG_RANDOM_SEED,
				($urandom_range(99) < 5) ? 0 : $urandom_range(65535, 1));
	endtask

	task automatic test_defaults();
		send_item(mk_item(tsl_pkg::KIND_RESTART, 8191));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 0));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 1));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, MAX_BLOCK));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 8191));
	endtask

	// 60 bpm, quarter notes, 8 kHz: 2000 samples is exactly a quarter cycle
	task automatic test_phase_landmarks();
		wait_idle();
		write_reg(tsl_pkg::REG_TEMPO_BPM, 60);
		write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 8000);
		write_reg(tsl_pkg::REG_RATE_DIVISION, 4);
		write_reg(tsl_pkg::REG_WAVE_SHAPE, tsl_pkg::SHAPE_TRIANGLE);
		send_item(mk_item(tsl_pkg::KIND_RESTART, 0));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 2000));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 4000));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 2000));
		wait_idle();
		write_reg(tsl_pkg::REG_WAVE_SHAPE, tsl_pkg::SHAPE_SQUARE);
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 4000));
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 4000));
		wait_idle();
		write_reg(tsl_pkg::REG_WAVE_SHAPE, tsl_pkg::SHAPE_SAW_DOWN);
		send_item(mk_item(tsl_pkg::KIND_RESTART, 4096));
	endtask

	task automatic test_range_limits();
		wait_idle();
		write_reg(tsl_pkg::REG_RATE_DIVISION, 15);
		write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 0);
		write_reg(tsl_pkg::REG_TEMPO_BPM, 999);
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, MAX_BLOCK));
		wait_idle();
		write_reg(tsl_pkg::REG_TEMPO_BPM, 0);
		send_item(mk_item(tsl_pkg::KIND_ADVANCE, 100));
	endtask

	// Fast 1/16 triplets at 999 bpm cross many cycles per block
	task automatic test_sample_hold();
		wait_idle();
		write_reg(tsl_pkg::REG_WAVE_SHAPE, tsl_pkg::SHAPE_SAMPLE_HOLD);
		write_reg(tsl_pkg::REG_RANDOM_SEED, 0);
		write_reg(tsl_pkg::REG_TEMPO_BPM, 999);
		write_reg(tsl_pkg::REG_RATE_DIVISION, 1);
		write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 8000);
		repeat (3) send_item(mk_item(tsl_pkg::KIND_ADVANCE, MAX_BLOCK));
		send_item(mk_item(tsl_pkg::KIND_RESTART, 0));
		wait_idle();
		write_reg(tsl_pkg::REG_RANDOM_SEED, 65535);
		repeat (2) send_item(mk_item(tsl_pkg::KIND_ADVANCE, MAX_BLOCK));
	endtask

	// Output held off while the sender keeps offering, so in_stall backs up
	task automatic test_backpressure();
		wait_idle();
		write_reg(tsl_pkg::REG_SAMPLE_RATE_HZ, 48000);
		write_reg(tsl_pkg::REG_TEMPO_BPM, 180);
		tx_idle_pct = 0;
		@(posedge clk);
		long_hold = 1'b1;
		repeat (12) send_item(random_item());
		long_hold = 1'b0;
	endtask

	task automatic test_random(int tx_pct, int rx_pct, int items);
		int sent;
		int run;
		sent = 0;
		while (sent < items) begin
			wait_idle();
			tx_idle_pct = tx_pct;
			rx_idle_pct = rx_pct;
			pick_setting();
			run = $urandom_range(120, 40);
			repeat (run) send_item(random_item());
			sent += run;
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && held_cycles < HOLD_CYCLES) begin
				out_stall = 1'b1;
				held_cycles++;
			end else begin
				if (!long_hold)
					held_cycles = 0;
				out_stall = ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin
		tsl_pkg::out_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_lfo.size() == 0) begin
					note_error($sformatf("unexpected transfer: value %0d phase %h wrap %b",
						out_item.lfo_value, out_item.phase_now, out_item.cycle_wrapped));
				end else begin
					want = expected_lfo.pop_front();
					if (out_item.lfo_value !== want.lfo_value ||
							out_item.phase_now !== want.phase_now ||
							out_item.cycle_wrapped !== want.cycle_wrapped)
						note_error($sformatf(
							"expected value %0d phase %h wrap %b, got %0d %h %b",
							want.lfo_value, want.phase_now, want.cycle_wrapped,
							out_item.lfo_value, out_item.phase_now, out_item.cycle_wrapped));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = tsl_pkg::REG_RATE_DIVISION;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		long_hold = 1'b0;
		tx_idle_pct = 15;
		rx_idle_pct = 72;
		r_div = tsl_pkg::RST_RATE_DIVISION;
		r_shape = tsl_pkg::RST_WAVE_SHAPE;
		r_bpm = tsl_pkg::RST_TEMPO_BPM;
		r_sr = tsl_pkg::RST_SAMPLE_RATE_HZ;
		lfsr = tsl_pkg::RST_RANDOM_SEED;
		lfo_phase = '0;
		sh_value = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_phase_landmarks();
		test_range_limits();
		test_sample_hold();
		test_random(15, 72, 600);
		test_backpressure();
		test_random(72, 15, 550);
		test_random(0, 0, 550);

		wait_idle();
		repeat (ADVANCE_LATENCY) @(posedge clk);
		if (expected_lfo.size() != 0)
			note_error("results still outstanding at end of run");
		if (errors == 0)
			$display("tb_tempo_synced_lfo: clean");
		else
			$display("tb_tempo_synced_lfo: errors");
		$finish;
	end

endmodule

// ===== tempo_synced_lfo.f =====
src/tsl_pkg.sv
src/tsl_divider.sv
src/tsl_wave.sv
src/tempo_synced_lfo.sv
verif/tb_tempo_synced_lfo.sv
